>>> hw/rtl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the indexed sequence store: command and
// status codes, controller states and the control/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package iss_pkg;

    // Fixed field widths of the channels
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int EXT_W   = 64;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;     // capture command, position, word and status
        logic rd_at_pos;    // read the entry at the latched position
        logic rd_at_idx;    // read the entry at the shift index
        logic wr_shift;     // write read data to its shifted slot
        logic wr_insert;    // write the new word at the latched position
        logic cnt_clear;
        logic cnt_inc;
        logic cnt_dec;
        logic idx_load_ins; // index = count - 1
        logic idx_load_rem; // index = position + 1
        logic idx_step;     // down for insert, up for remove
        logic res_capture;  // result word = read data
        logic out_load;     // move the finished result into the output register
    } iss_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t op;           // latched command
        logic ok;           // latched status is ok
        logic ins_tail;     // insert goes at the end, nothing to shift
        logic rem_tail;     // remove takes the last entry, nothing to shift
        logic shift_last;   // current shift step is the final one
        logic out_full;     // output register holds an untaken result
    } iss_stat_t;

endpackage

>>> hw/rtl/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// Controller state machine: decodes a latched command and walks the datapath
// through the read, shift and write steps it needs.
// ----------------------------------------------------------------------------
module iss_ctrl
    import iss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    input  iss_stat_t stat,
    output iss_ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.latch_in = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (stat.op) inside
                        CMD_CLEAR:
                        begin
                            ctrl.cnt_clear = 1'b1;
                            state_next     = S_DONE;
                        end
                        CMD_INSERT:
                        begin
                            if (stat.ins_tail)
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                ctrl.idx_load_ins = 1'b1;
                                state_next        = S_SH_RD;
                            end
                        end
                        CMD_REMOVE, CMD_GET:
                        begin
                            ctrl.rd_at_pos = 1'b1;
                            state_next     = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ctrl.res_capture = 1'b1;
                if (stat.op == CMD_GET)
                begin
                    state_next = S_DONE;
                end
                else if (stat.rem_tail)
                begin
                    ctrl.cnt_dec = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    ctrl.idx_load_rem = 1'b1;
                    state_next        = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                ctrl.rd_at_idx = 1'b1;
                state_next     = S_SH_WR;
            end
            S_SH_WR:
            begin
                ctrl.wr_shift = 1'b1;
                if (!stat.shift_last)
                begin
                    ctrl.idx_step = 1'b1;
                    state_next    = S_SH_RD;
                end
                else if (stat.op == CMD_INSERT)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    ctrl.cnt_dec = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_INS_WR:
            begin
                ctrl.wr_insert = 1'b1;
                ctrl.cnt_inc   = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_full || out_ready)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/iss_datapath.sv
// ----------------------------------------------------------------------------
// iss_datapath
// Entry memory, count, shift index, command latch and output register.
// Shifting moves one entry at a time, as a read from the memory followed
// by a write of that entry to its shifted slot.
// ----------------------------------------------------------------------------
module iss_datapath
    import iss_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  iss_ctrl_t           ctrl,
    output iss_stat_t           stat,
    input  logic [1:0]          command,
    input  logic [POS_W-1:0]    position,
    input  logic [DATA_W-1:0]   data_in,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [DATA_W-1:0]   data_out,
    output logic [1:0]          status,
    output logic [COUNT_W-1:0]  item_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    // Entry memory and its registered read port
    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] rd_q;

    // Latched command
    cmd_t                 op_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [WORD_BITS-1:0] word_reg;
    status_t              st_reg;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        idx_next;
    logic [DATA_W-1:0]    res_reg;

    logic                 out_valid_reg;
    logic [DATA_W-1:0]    data_out_reg;
    status_t              status_reg;
    logic [COUNT_W-1:0]   item_count_reg;

    logic [MW-1:0]        cnt_ext;
    logic [MW-1:0]        pos_ext;
    logic [MW-1:0]        in_pos_ext;
    logic [MW-1:0]        idx_ext;
    logic [EXT_W-1:0]     din_ext;
    logic [EXT_W-1:0]     rd_ext;
    status_t              in_status;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 wr_en;

    assign cnt_ext    = MW'(count_reg);
    assign pos_ext    = MW'(pos_reg);
    assign in_pos_ext = MW'(position);
    assign idx_ext    = MW'(idx_reg);
    assign din_ext    = EXT_W'(data_in);
    assign rd_ext     = EXT_W'(rd_q);

    // Status of an incoming command against the current count
    always_comb
    begin
        in_status = ST_OK;
        case (cmd_t'(command)) inside
            CMD_INSERT:
            begin
                if (in_pos_ext > cnt_ext)
                begin
                    in_status = ST_BAD_POS;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    in_status = ST_FULL;
                end
            end
            CMD_REMOVE, CMD_GET:
            begin
                if (count_reg == '0)
                begin
                    in_status = ST_EMPTY;
                end
                else if (in_pos_ext >= cnt_ext)
                begin
                    in_status = ST_BAD_POS;
                end
            end
            default:
            begin
                in_status = ST_OK;
            end
        endcase
    end

    // Flags for the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.ok         = (st_reg == ST_OK);
        stat.ins_tail   = (pos_ext == cnt_ext);
        stat.rem_tail   = ((pos_ext + MW'(1)) == cnt_ext);
        stat.shift_last = (op_reg == CMD_INSERT) ? (idx_ext == pos_ext)
                                                 : ((idx_ext + MW'(1)) == cnt_ext);
        stat.out_full   = out_valid_reg;
    end

    // Memory port addressing
    always_comb
    begin
        rd_addr = ctrl.rd_at_pos ? pos_ext[AW-1:0] : idx_reg;
        wr_en   = ctrl.wr_shift || ctrl.wr_insert;
        if (ctrl.wr_insert)
        begin
            wr_addr = pos_ext[AW-1:0];
            wr_data = word_reg;
        end
        else
        begin
            wr_addr = (op_reg == CMD_INSERT) ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));
            wr_data = rd_q;
        end
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_at_pos || ctrl.rd_at_idx)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    // Command latch and result word
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            op_reg   <= cmd_t'(command);
            pos_reg  <= position;
            word_reg <= din_ext[WORD_BITS-1:0];
            st_reg   <= in_status;
            res_reg  <= '0;
        end
        else if (ctrl.res_capture)
        begin
            res_reg <= rd_ext[DATA_W-1:0];
        end
    end

    // Count and shift index
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.cnt_clear)
        begin
            count_next = '0;
        end
        else if (ctrl.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end

        idx_next = idx_reg;
        if (ctrl.idx_load_ins)
        begin
            idx_next = cnt_ext[AW-1:0] - AW'(1);
        end
        else if (ctrl.idx_load_rem)
        begin
            idx_next = pos_ext[AW-1:0] + AW'(1);
        end
        else if (ctrl.idx_step)
        begin
            idx_next = (op_reg == CMD_INSERT) ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            data_out_reg   <= res_reg;
            status_reg     <= st_reg;
            item_count_reg <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign status     = status_reg;
    assign item_count = item_count_reg;

`ifndef SYNTHESIS
    // Count never exceeds the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Count moves by one step or clears
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == '0 || count_reg == $past(count_reg) + CW'(1)
             || count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count jumped");

    // A failed command delivers a zero word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (data_out_reg == '0))
        else $error("nonzero data with error status");

    // A result is never loaded over an untaken one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.out_load && out_valid_reg) |-> out_ready)
        else $error("output overrun");
`endif

endmodule

>>> hw/rtl/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered sequence of up to CAPACITY words with insert, remove, get and
// clear at a position; one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, position and data_in.
//   Output channel (out_valid/out_ready) carries data_out, status and
//   item_count, one transfer per accepted command.
//   The block works on one command at a time; in_ready is high only while
//   the controller is idle. A clear or failed command goes from decode
//   straight to done; a get reads its entry first. An insert or remove
//   also shifts each entry between the position and the end, one at a
//   time, by a read and then a write to its shifted slot, so insert/remove
//   time grows with the entries to be moved. The next command is taken in
//   the cycle after the result is loaded.
//   A finished result sits in the output register and a new command can be
//   taken while it waits; a second result waits in the controller until the
//   receiver takes the first. Reset empties the sequence at once; entry
//   contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module indexed_sequence_store
    import iss_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic [POS_W-1:0]    position,
    input  logic [DATA_W-1:0]   data_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DATA_W-1:0]   data_out,
    output logic [1:0]          status,
    output logic [COUNT_W-1:0]  item_count
);

    iss_ctrl_t ctrl;
    iss_stat_t stat;

    // Sequencer
    iss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Storage and result path
    iss_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .command    (command),
        .position   (position),
        .data_in    (data_in),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .data_out   (data_out),
        .status     (status),
        .item_count (item_count)
    );

endmodule
